[sv/rgb_to_yuv420_converter_macros.svh]
// Assertion macros shared by the RGB to YUV 4:2:0 converter modules.
`ifndef RGB_TO_YUV420_CONVERTER_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_MACROS_SVH

// Generic clocked property, disabled while reset is asserted
`define RGB2YUV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define RGB2YUV_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    `RGB2YUV_ASSERT(lbl, clk, rst_n, (cond) |-> (prop), msg)

// Next-cycle implication
`define RGB2YUV_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    `RGB2YUV_ASSERT(lbl, clk, rst_n, (cond) |=> (prop), msg)

`endif

[sv/rgb2yuv_pkg.sv]
// Shared types, widths and coefficients of the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package rgb2yuv_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Default frame-size limit
    localparam int MAX_DIMENSION_DEF = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Color sums fit in 16 bits; one spare bit absorbs the wrap of the subtractions
    localparam int SUM_W     = 17;
    localparam int SUM_SHIFT = 8;

    // Luma coefficients, rounding bias and studio offset
    localparam logic [SUM_W-1:0] Y_KR     = 17'd66;
    localparam logic [SUM_W-1:0] Y_KG     = 17'd129;
    localparam logic [SUM_W-1:0] Y_KB     = 17'd25;
    localparam logic [SUM_W-1:0] Y_BIAS   = 17'd128;
    localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;

    // Chroma coefficient magnitudes; bias is 128 rounding plus 128 << 8 offset
    localparam logic [SUM_W-1:0] CB_KR   = 17'd38;
    localparam logic [SUM_W-1:0] CB_KG   = 17'd74;
    localparam logic [SUM_W-1:0] CB_KB   = 17'd112;
    localparam logic [SUM_W-1:0] CR_KR   = 17'd112;
    localparam logic [SUM_W-1:0] CR_KG   = 17'd94;
    localparam logic [SUM_W-1:0] CR_KB   = 17'd18;
    localparam logic [SUM_W-1:0] C_BIAS  = 17'd32896;

    // Converted samples of one pixel
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } t_yuv;

    // Position flags of the pixel being retired
    typedef struct packed {
        logic chroma_valid;
        logic frame_end;
    } t_pos_flags;

endpackage

[sv/rgb2yuv_csc.sv]
// Color-space conversion of one RGB pixel into BT.601 studio-range Y, Cb, Cr.
`timescale 1ns / 1ps

module rgb2yuv_csc import rgb2yuv_pkg::*; (
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output t_yuv             o_yuv
);

    logic [SUM_W-1:0] w_r;
    logic [SUM_W-1:0] w_g;
    logic [SUM_W-1:0] w_b;
    logic [SUM_W-1:0] w_y_sum;
    logic [SUM_W-1:0] w_cb_sum;
    logic [SUM_W-1:0] w_cr_sum;

    // Widen the components to the sum width
    assign w_r = SUM_W'(i_red);
    assign w_g = SUM_W'(i_green);
    assign w_b = SUM_W'(i_blue);

    // Weighted sums; the true chroma sums are always positive after the bias
    assign w_y_sum  = Y_KR * w_r + Y_KG * w_g + Y_KB * w_b + Y_BIAS;
    assign w_cb_sum = C_BIAS + CB_KB * w_b - CB_KR * w_r - CB_KG * w_g;
    assign w_cr_sum = C_BIAS + CR_KR * w_r - CR_KG * w_g - CR_KB * w_b;

    // Drop the fraction and add the luma offset
    assign o_yuv.luma = w_y_sum[SUM_SHIFT+PIX_W-1:SUM_SHIFT] + Y_OFFSET;
    assign o_yuv.cb   = w_cb_sum[SUM_SHIFT+PIX_W-1:SUM_SHIFT];
    assign o_yuv.cr   = w_cr_sum[SUM_SHIFT+PIX_W-1:SUM_SHIFT];

endmodule

[sv/rgb2yuv_pos.sv]
// Column and row counters with chroma-site and end-of-frame flags.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_converter_macros.svh"

module rgb2yuv_pos import rgb2yuv_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [CFG_W-1:0] i_frame_width,
    input  logic [CFG_W-1:0] i_frame_height,
    output t_pos_flags       o_flags
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int CMP_W = (((CNT_W + 1) > CFG_W) ? (CNT_W + 1) : CFG_W) + 1;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [CMP_W-1:0] w_width_ext;
    logic [CMP_W-1:0] w_height_ext;
    logic [CMP_W-1:0] w_width_eff;
    logic [CMP_W-1:0] w_height_eff;
    logic             w_last_col;
    logic             w_last_row;

    // Clamp the frame size into 1 .. MAX_DIMENSION
    assign w_width_ext  = CMP_W'(i_frame_width);
    assign w_height_ext = CMP_W'(i_frame_height);

    always_comb begin
        if (w_width_ext == '0) begin
            w_width_eff = CMP_W'(1);
        end else if (w_width_ext > CMP_W'(MAX_DIMENSION)) begin
            w_width_eff = CMP_W'(MAX_DIMENSION);
        end else begin
            w_width_eff = w_width_ext;
        end
        if (w_height_ext == '0) begin
            w_height_eff = CMP_W'(1);
        end else if (w_height_ext > CMP_W'(MAX_DIMENSION)) begin
            w_height_eff = CMP_W'(MAX_DIMENSION);
        end else begin
            w_height_eff = w_height_ext;
        end
    end

    // A counter at or past the last position ends its row or frame here
    assign w_last_col = (CMP_W'(r_col) + CMP_W'(1)) >= w_width_eff;
    assign w_last_row = (CMP_W'(r_row) + CMP_W'(1)) >= w_height_eff;

    // Chroma only on even sites inside the even-rounded frame
    assign o_flags.chroma_valid = !r_col[0] && !r_row[0] && !w_last_col && !w_last_row;
    assign o_flags.frame_end    = w_last_col && w_last_row;

    // Step to the next raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `RGB2YUV_ASSERT_IMP(a_end_no_chroma, i_clk, i_rst_n, o_flags.frame_end, !o_flags.chroma_valid, "chroma flagged on the last pixel of a frame")
    `RGB2YUV_ASSERT_NEXT(a_col_wrap, i_clk, i_rst_n, i_advance && w_last_col, r_col == '0, "column did not wrap at end of row")
    `RGB2YUV_ASSERT_NEXT(a_hold_pos, i_clk, i_rst_n, !i_advance, $stable(r_col) && $stable(r_row), "position moved without an item")

endmodule

[sv/rgb_to_yuv420_converter.sv]
// An accepted input item passes the input register and then the result register before
// its result can be taken from the result channel.
// Throughput: one pixel per clock; a stalled result holds one further pixel in the input register.
// Configuration writes take effect on the next cycle and are always ready.
// Reset (synchronous, active low) empties both registers, zeroes the column and row
// counters and loads a frame size of 640 by 480.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_converter_macros.svh"

module rgb_to_yuv420_converter import rgb2yuv_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Pixel input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_red,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_blue,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_luma,
    output logic [PIX_W-1:0]     o_chroma_blue,
    output logic [PIX_W-1:0]     o_chroma_red,
    output logic                 o_chroma_valid,
    output logic                 o_frame_end
);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_red;
    logic [PIX_W-1:0] r_s1_green;
    logic [PIX_W-1:0] r_s1_blue;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_luma;
    logic [PIX_W-1:0] r_cb;
    logic [PIX_W-1:0] r_cr;
    logic             r_cvalid;
    logic             r_frame_end;
    logic             n_out_valid;
    logic             w_in_accept;
    logic             w_s1_advance;
    t_yuv             w_yuv;
    t_pos_flags       w_flags;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: advance when the result register is free or being drained
    assign w_s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready   = !r_s1_valid || w_s1_advance;
    assign w_in_accept  = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
        end
    end

    // Color conversion and raster position
    rgb2yuv_csc u_csc (
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .o_yuv   (w_yuv)
    );

    rgb2yuv_pos #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_s1_advance),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_flags        (w_flags)
    );

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Zero the chroma on pixels that carry none
    always_ff @(posedge i_clk) begin
        if (w_s1_advance) begin
            r_luma      <= w_yuv.luma;
            r_cb        <= w_flags.chroma_valid ? w_yuv.cb : '0;
            r_cr        <= w_flags.chroma_valid ? w_yuv.cr : '0;
            r_cvalid    <= w_flags.chroma_valid;
            r_frame_end <= w_flags.frame_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_luma         = r_luma;
    assign o_chroma_blue  = r_cb;
    assign o_chroma_red   = r_cr;
    assign o_chroma_valid = r_cvalid;
    assign o_frame_end    = r_frame_end;

    `RGB2YUV_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_s1_advance, r_s1_valid && $stable(r_s1_red) && $stable(r_s1_blue), "stalled input register lost its item")
    `RGB2YUV_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, w_s1_advance, r_out_valid, "advanced item missing from result register")
    `RGB2YUV_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n, w_in_accept, r_s1_valid, "accepted item missing from input register")

endmodule

[dv/testbench.sv]
// Self-checking testbench of the RGB to YUV 4:2:0 converter with a scoreboard predictor.
`timescale 1ns / 1ps
module testbench;
    import rgb2yuv_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_PIXELS = 750;
    localparam int STEADY_FIRST  = 250;
    localparam int STEADY_LAST   = 450;
    localparam int IDLE_PCT      = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIM_LIMIT     = MAX_DIMENSION_DEF;
    localparam int CFG_MAX       = (1 << CFG_W) - 1;

    // Unused register slots; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        t_yuv       yuv;
        t_pos_flags flags;
    } t_yuv_sample;

    // Predict the converted samples and compare them against the result stream
    class yuv420_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      column;
        int unsigned      row;
        t_yuv_sample      expected_q[$];
        int unsigned      mismatch_count;

        function new();
            width_reg      = FRAME_WIDTH_RST;
            height_reg     = FRAME_HEIGHT_RST;
            column         = 0;
            row            = 0;
            mismatch_count = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
            case (index)
                CFG_FRAME_WIDTH:  width_reg = data;
                CFG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        // Zero counts as one, anything past the limit as the limit
        function int unsigned clamp_dim(input logic [CFG_W-1:0] value);
            if (value == 0)
                return 1;
            if (value > DIM_LIMIT)
                return DIM_LIMIT;
            return 32'(value);
        endfunction

        function void note_pixel(input logic [PIX_W-1:0] red, green, blue);
            int unsigned w;
            int unsigned h;
            int          r;
            int          g;
            int          b;
            int          y_sum;
            int          cb_sum;
            int          cr_sum;
            bit          last_col;
            bit          last_row;
            t_yuv_sample s;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            r = int'(red);
            g = int'(green);
            b = int'(blue);
            // Chroma sums carry the +128 offset as a bias of 128 << 8, so they stay positive
            y_sum  = 66 * r + 129 * g + 25 * b + 128;
            cb_sum = -38 * r - 74 * g + 112 * b + 128 + 32768;
            cr_sum = 112 * r - 94 * g - 18 * b + 128 + 32768;
            last_col = (column + 1) >= w;
            last_row = (row + 1) >= h;
            s.flags.chroma_valid = (column % 2 == 0) && (row % 2 == 0) &&
                                   (column + 1 < w) && (row + 1 < h);
            s.flags.frame_end = last_col && last_row;
            s.yuv.luma = PIX_W'((y_sum >> 8) + 16);
            s.yuv.cb   = s.flags.chroma_valid ? PIX_W'(cb_sum >> 8) : '0;
            s.yuv.cr   = s.flags.chroma_valid ? PIX_W'(cr_sum >> 8) : '0;
            expected_q = {expected_q, s};
            // Advance the raster position; a shrunk size wraps on the current pixel
            if (last_col) begin
                column = 0;
                row = last_row ? 0 : row + 1;
            end else begin
                column = column + 1;
            end
        endfunction

        function void check_result(input t_yuv_sample got);
            t_yuv_sample want;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item: Y=%0d Cb=%0d Cr=%0d cvalid=%0b end=%0b",
                             got.yuv.luma, got.yuv.cb, got.yuv.cr,
                             got.flags.chroma_valid, got.flags.frame_end);
                return;
            end
            want = expected_q.pop_front();
            if (got.yuv.luma !== want.yuv.luma || got.yuv.cb !== want.yuv.cb ||
                    got.yuv.cr !== want.yuv.cr ||
                    got.flags.chroma_valid !== want.flags.chroma_valid ||
                    got.flags.frame_end !== want.flags.frame_end) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: expected Y=%0d Cb=%0d Cr=%0d cvalid=%0b end=%0b, %s",
                             want.yuv.luma, want.yuv.cb, want.yuv.cr,
                             want.flags.chroma_valid, want.flags.frame_end,
                             $sformatf("got Y=%0d Cb=%0d Cr=%0d cvalid=%0b end=%0b",
                                       got.yuv.luma, got.yuv.cb, got.yuv.cr,
                                       got.flags.chroma_valid, got.flags.frame_end));
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_red;
    logic [PIX_W-1:0]     i_green;
    logic [PIX_W-1:0]     i_blue;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PIX_W-1:0]     o_luma;
    logic [PIX_W-1:0]     o_chroma_blue;
    logic [PIX_W-1:0]     o_chroma_red;
    logic                 o_chroma_valid;
    logic                 o_frame_end;

    yuv420_scoreboard board;
    bit               steady_stream = 1'b0;
    int unsigned      cycle_count = 0;

    rgb_to_yuv420_converter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_luma         (o_luma),
        .o_chroma_blue  (o_chroma_blue),
        .o_chroma_red   (o_chroma_red),
        .o_chroma_valid (o_chroma_valid),
        .o_frame_end    (o_frame_end)
    );

    always begin
        i_clk = 1'b0;
        #CLK_LOW;
        i_clk = 1'b1;
        #CLK_HIGH;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Check each accepted result item and stall the result channel at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                board.check_result({o_luma, o_chroma_blue, o_chroma_red,
                                    o_chroma_valid, o_frame_end});
            i_out_ready <= steady_stream || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(index, data);
    endtask

    // Write both size registers, optionally poke the unused slots, then drop valid
    task automatic set_frame(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                             input bit poke_spare);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        if (poke_spare) begin
            write_reg(CFG_SPARE_LO, CFG_W'($urandom_range(0, CFG_MAX)));
            write_reg(CFG_SPARE_HI, CFG_W'($urandom_range(0, CFG_MAX)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the pixel until accepted; valid stays high for a following item
    task automatic send_pixel(input logic [PIX_W-1:0] red, green, blue);
        while (!steady_stream && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red      <= red;
        i_green    <= green;
        i_blue     <= blue;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(red, green, blue);
    endtask

    task automatic wait_drain();
        while (board.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_component();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Mostly tiny frames, now and then a degenerate or oversized one
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return CFG_W'(DIM_LIMIT);
            2:       return CFG_W'($urandom_range(DIM_LIMIT + 1, CFG_MAX));
            3:       return CFG_W'(CFG_MAX);
            4:       return CFG_W'($urandom_range(9, 40));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        logic [PIX_W-1:0] corner_red[12];
        logic [PIX_W-1:0] corner_green[12];
        logic [PIX_W-1:0] corner_blue[12];
        int unsigned      corner_idx;
        int unsigned      random_sent;
        int unsigned      phase_len;

        corner_red   = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
                         8'd128, 8'd1, 8'd16, 8'd85};
        corner_green = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0,
                         8'd128, 8'd2, 8'd235, 8'd170};
        corner_blue  = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                         8'd128, 8'd4, 8'd240, 8'd51};
        corner_idx  = 0;
        random_sent = 0;
        board = new();

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset frame size: a few pixels into the first row
        repeat (5) begin
            send_pixel(corner_red[corner_idx % 12], corner_green[corner_idx % 12],
                       corner_blue[corner_idx % 12]);
            corner_idx++;
        end
        i_in_valid <= 1'b0;
        wait_drain();

        // Odd 3x3 frame entered mid-row: the column already past the edge wraps at once
        set_frame(CFG_W'(3), CFG_W'(3), 1'b1);
        repeat (14) begin
            send_pixel(corner_red[corner_idx % 12], corner_green[corner_idx % 12],
                       corner_blue[corner_idx % 12]);
            corner_idx++;
        end
        i_in_valid <= 1'b0;
        wait_drain();

        // Zero sizes act as a single pixel per frame
        set_frame('0, '0, 1'b0);
        repeat (3) begin
            send_pixel(corner_red[corner_idx % 12], corner_green[corner_idx % 12],
                       corner_blue[corner_idx % 12]);
            corner_idx++;
        end
        i_in_valid <= 1'b0;
        wait_drain();

        // Oversized sizes clamp to the limit
        set_frame(CFG_W'(DIM_LIMIT + 1), CFG_W'(CFG_MAX), 1'b0);
        repeat (3) begin
            send_pixel(corner_red[corner_idx % 12], corner_green[corner_idx % 12],
                       corner_blue[corner_idx % 12]);
            corner_idx++;
        end
        i_in_valid <= 1'b0;
        wait_drain();

        // Random frames, one size per stretch
        while (random_sent < RANDOM_PIXELS) begin
            set_frame(pick_dim(), pick_dim(), $urandom_range(0, 9) == 0);
            phase_len = $urandom_range(12, 60);
            repeat (phase_len) begin
                steady_stream = (random_sent >= STEADY_FIRST) && (random_sent < STEADY_LAST);
                send_pixel(pick_component(), pick_component(), pick_component());
                random_sent++;
            end
            i_in_valid <= 1'b0;
            wait_drain();
        end
        steady_stream = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.expected_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
